### rtl/core/sslod_pkg.sv
// Shared constants and types for the screen-size level-of-detail selector.
package sslod_pkg;
  localparam int MaxLevels = 4;
  localparam int MinDistance = 3;
  localparam logic [16:0] FullFade = 17'd65536;

  localparam logic [2:0] RegLodEnable = 3'd0;
  localparam logic [2:0] RegBias = 3'd1;
  localparam logic [2:0] RegForced = 3'd2;
  localparam logic [2:0] RegXfEnable = 3'd3;
  localparam logic [2:0] RegXfMs = 3'd4;
  localparam logic [2:0] RegHeight = 3'd5;
  localparam logic [2:0] RegCount = 3'd6;
  localparam logic [2:0] RegThresh = 3'd7;

  typedef struct packed {
    logic load;      // capture the item and start the distance
    logic sqrt_go;   // start the square root
    logic div1_go;   // start the fade division
    logic div2_go;   // start the screen-size division
    logic commit;    // update level state and load the result
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } sts_t;
endpackage

### rtl/core/screen_size_lod_selector.sv
// Top level of the screen-size level-of-detail selector.
//  channel | signals                     | direction
//  in      | in_valid_i / in_stall_o     | item in
//  out     | out_valid_o / out_stall_i   | result out
//  cfg     | cfg_we_i, cfg_idx_i, data   | register write
// An item runs through 26 square-root steps and then two 48-step divisions
// in one shared divider before the result is committed.
// Reset is asynchronous and active low; registers take their documented values.
// The next item waits until the result register is free; out_stall_i holds it.
module screen_size_lod_selector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic signed [23:0] center_z_i,
  input  logic [22:0]        radius_i,
  input  logic signed [23:0] camera_x_i,
  input  logic signed [23:0] camera_y_i,
  input  logic signed [23:0] camera_z_i,
  input  logic [15:0]        elapsed_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         active_level_o,
  output logic [1:0]         fading_from_o,
  output logic [16:0]        fade_amount_o,
  output logic               switched_o
);
  import sslod_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sslod_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  sslod_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .center_x_i, .center_y_i, .center_z_i, .radius_i,
    .camera_x_i, .camera_y_i, .camera_z_i, .elapsed_ms_i,
    .active_level_o, .fading_from_o, .fade_amount_o, .switched_o
  );
endmodule

### rtl/core/sslod_ctrl.sv
// Sequencer for one tick: sum of squares, square root, two divisions, commit.
module sslod_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  sslod_pkg::sts_t sts_i,
  output sslod_pkg::cmd_t cmd_o
);
  import sslod_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StSum, StSqrt, StDiv1, StDiv2, StCommit
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load    = (state_q == StIdle) && in_valid_i && !in_stall_o;
    cmd_o.sqrt_go = (state_q == StSum);
    cmd_o.div1_go = (state_q == StSqrt) && sts_i.sqrt_done;
    cmd_o.div2_go = (state_q == StDiv1) && sts_i.div_done;
    cmd_o.commit  = (state_q == StCommit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle:   if (cmd_o.load) state_q <= StSum;
        StSum:    state_q <= StSqrt;
        StSqrt:   if (sts_i.sqrt_done) state_q <= StDiv1;
        StDiv1:   if (sts_i.div_done) state_q <= StDiv2;
        StDiv2:   if (sts_i.div_done) state_q <= StCommit;
        StCommit: begin
          state_q     <= StIdle;
          out_valid_q <= 1'b1;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end
endmodule

### rtl/core/sslod_datapath.sv
// Distance, square root, shared divider, level selection and result registers.
module sslod_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sslod_pkg::cmd_t     cmd_i,
  output sslod_pkg::sts_t     sts_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic signed [23:0]  center_x_i,
  input  logic signed [23:0]  center_y_i,
  input  logic signed [23:0]  center_z_i,
  input  logic [22:0]         radius_i,
  input  logic signed [23:0]  camera_x_i,
  input  logic signed [23:0]  camera_y_i,
  input  logic signed [23:0]  camera_z_i,
  input  logic [15:0]         elapsed_ms_i,
  output logic [1:0]          active_level_o,
  output logic [1:0]          fading_from_o,
  output logic [16:0]         fade_amount_o,
  output logic                switched_o
);
  import sslod_pkg::*;

  // Configuration registers.
  logic        lod_en_q, xf_en_q;
  logic signed [17:0] bias_q;
  logic signed [2:0]  forced_q;
  logic [15:0] xf_ms_q, height_q;
  logic [2:0]  count_q;
  logic [63:0] thr_q;
  // Level state.
  logic [1:0]  cur_q, prev_q;
  logic [15:0] timer_q;
  logic [16:0] prog_q;

  // Item capture.
  logic [24:0] ax_q, ay_q, az_q;
  logic [22:0] rad_q;
  logic [15:0] el_q;
  logic [50:0] sum_q;

  function automatic logic [24:0] absdiff(logic signed [23:0] a, logic signed [23:0] b);
    logic signed [24:0] d;
    d = 25'(a) - 25'(b);
    return d[24] ? 25'(-d) : d;
  endfunction

  // Square root: one result bit per cycle.
  logic [50:0] rem_q;
  logic [25:0] root_q;
  logic [4:0]  sq_cnt_q;
  logic        sq_busy_q;
  logic [52:0] trial;
  logic [52:0] rem_sh;
  assign rem_sh = {rem_q, 2'b00} | 53'(sum_q[50:0] >> {sq_cnt_q, 1'b0} & 51'd3);
  assign trial  = {25'd0, root_q, 2'b01};

  // Shared restoring divider: 48-bit dividend, 41-bit divisor, one bit a cycle.
  logic [47:0] dvd_q, quo_q;
  logic [40:0] drem_q;
  logic [40:0] dvs_q;
  logic [5:0]  dv_cnt_q;
  logic        dv_busy_q;
  logic [41:0] drem_sh;
  assign drem_sh = {drem_q, dvd_q[47]};

  logic [16:0] fade_q_lim;
  logic        mul_go_q;
  logic [25:0] dist_c;
  logic [15:0] h_c;
  logic [2:0]  cnt_c;
  logic [15:0] t_sum_c;

  assign dist_c = (root_q < 26'(MinDistance)) ? 26'(MinDistance) : root_q;
  assign h_c    = (height_q == 16'd0) ? 16'd256 : height_q;
  assign cnt_c  = (count_q > 3'(MaxLevels)) ? 3'(MaxLevels) : count_q;
  assign t_sum_c = (17'(timer_q) + 17'(el_q) > 17'hFFFF) ? 16'hFFFF
                 : 16'(17'(timer_q) + 17'(el_q));

  logic sqrt_fin_q, div_fin_q;
  assign sts_o.sqrt_done = sqrt_fin_q;
  assign sts_o.div_done = div_fin_q;

  logic [47:0] q1_q; // fade quotient
  logic [40:0] dmul_q;
  logic        first_div_q;

  // Fade condition used by the commit logic.
  logic        fading_c;
  assign fading_c = xf_en_q && (prev_q != cur_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= absdiff(center_x_i, camera_x_i);
      ay_q  <= absdiff(center_y_i, camera_y_i);
      az_q  <= absdiff(center_z_i, camera_z_i);
      rad_q <= radius_i;
      el_q  <= elapsed_ms_i;
    end
    // Squares are narrow enough per term; one multiplier per axis.
    if (cmd_i.sqrt_go) begin
      sum_q <= 51'(ax_q * ax_q) + 51'(ay_q * ay_q) + 51'(az_q * az_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q  <= 1'b0;
      sqrt_fin_q <= 1'b0;
      sq_cnt_q   <= '0;
      rem_q      <= '0;
      root_q     <= '0;
    end else begin
      sqrt_fin_q <= 1'b0;
      if (cmd_i.sqrt_go) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= 5'd25;
        rem_q     <= '0;
        root_q    <= '0;
      end else if (sq_busy_q) begin
        if (rem_sh >= trial) begin
          rem_q  <= 51'(rem_sh - trial);
          root_q <= {root_q[24:0], 1'b1};
        end else begin
          rem_q  <= 51'(rem_sh);
          root_q <= {root_q[24:0], 1'b0};
        end
        if (sq_cnt_q == 5'd0) begin
          sq_busy_q  <= 1'b0;
          sqrt_fin_q <= 1'b1;
        end
        sq_cnt_q <= sq_cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      div_fin_q <= 1'b0;
      mul_go_q  <= 1'b0;
      dv_cnt_q  <= '0;
      dvd_q     <= '0;
      dvs_q     <= '0;
      drem_q    <= '0;
      quo_q     <= '0;
      q1_q      <= '0;
      dmul_q    <= '0;
      first_div_q <= 1'b0;
    end else begin
      div_fin_q <= 1'b0;
      mul_go_q  <= 1'b0;
      if (cmd_i.div1_go) begin
        dvd_q     <= {16'd0, t_sum_c, 16'd0};
        dvs_q     <= 41'((xf_ms_q == 16'd0) ? 16'd1 : xf_ms_q);
        drem_q    <= '0;
        quo_q     <= '0;
        dv_cnt_q  <= 6'd47;
        dv_busy_q <= 1'b1;
        first_div_q <= 1'b1;
      end else if (cmd_i.div2_go) begin
        // Product registered in dmul_q before the divider is loaded with it.
        dmul_q    <= 41'(dist_c * h_c);
        mul_go_q  <= 1'b1;
        first_div_q <= 1'b0;
      end else if (mul_go_q) begin
        dvd_q     <= {rad_q, 25'd0};
        dvs_q     <= dmul_q;
        drem_q    <= '0;
        quo_q     <= '0;
        dv_cnt_q  <= 6'd47;
        dv_busy_q <= 1'b1;
      end else if (dv_busy_q) begin
        dvd_q <= {dvd_q[46:0], 1'b0};
        if (drem_sh >= {1'b0, dvs_q}) begin
          drem_q <= 41'(drem_sh - {1'b0, dvs_q});
          quo_q  <= {quo_q[46:0], 1'b1};
        end else begin
          drem_q <= drem_sh[40:0];
          quo_q  <= {quo_q[46:0], 1'b0};
        end
        if (dv_cnt_q == 6'd0) begin
          dv_busy_q <= 1'b0;
          div_fin_q <= 1'b1;
          if (first_div_q) q1_q <= (drem_sh >= {1'b0, dvs_q}) ? {quo_q[46:0], 1'b1}
                                                              : {quo_q[46:0], 1'b0};
        end
        dv_cnt_q <= dv_cnt_q - 6'd1;
      end
    end
  end

  // Commit logic.
  logic [16:0] size_c;
  logic signed [19:0] adj_s;
  logic [16:0] adj_c;
  logic [1:0]  target_c;
  logic [1:0]  cur_d, prev_d;
  logic [15:0] timer_d;
  logic [16:0] prog_d;
  logic        forced_ok;

  assign size_c = (quo_q > 48'(FullFade)) ? FullFade : quo_q[16:0];
  assign adj_s  = 20'(size_c) - 20'(bias_q);
  assign adj_c  = adj_s[19] ? 17'd0 : (adj_s > 20'(FullFade)) ? FullFade : adj_s[16:0];
  assign fade_q_lim = (q1_q >= 48'(FullFade)) ? FullFade : q1_q[16:0];
  assign forced_ok = !forced_q[2] && (forced_q < $signed({1'b0, cnt_c}));

  always_comb begin
    target_c = 2'(cnt_c - 3'd1);
    for (int i = MaxLevels - 1; i >= 0; i--) begin
      if (3'(i) < cnt_c && adj_c > 17'(thr_q[16*i +: 16])) target_c = 2'(i);
    end
  end

  always_comb begin
    cur_d = cur_q; prev_d = prev_q; timer_d = timer_q; prog_d = prog_q;
    if (cnt_c != 3'd0 && lod_en_q) begin
      if (!forced_q[2]) begin
        if (forced_ok && forced_q[1:0] != cur_q) begin
          prev_d = cur_q; cur_d = forced_q[1:0]; timer_d = '0; prog_d = '0;
        end
      end else begin
        if (fading_c) begin
          timer_d = t_sum_c;
          prog_d  = fade_q_lim;
          if (fade_q_lim == FullFade) prev_d = cur_q;
        end
        if (target_c != cur_q) begin
          prev_d = cur_q; cur_d = target_c; timer_d = '0; prog_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lod_en_q <= 1'b1; bias_q <= '0; forced_q <= -3'sd1; xf_en_q <= 1'b1;
      xf_ms_q <= 16'd200; height_q <= 16'd256; count_q <= '0; thr_q <= '0;
      cur_q <= '0; prev_q <= '0; timer_q <= '0; prog_q <= FullFade;
      active_level_o <= '0; fading_from_o <= '0; fade_amount_o <= FullFade;
      switched_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegLodEnable: lod_en_q <= cfg_data_i[0];
          RegBias:      bias_q   <= cfg_data_i[17:0];
          RegForced:    forced_q <= cfg_data_i[2:0];
          RegXfEnable:  xf_en_q  <= cfg_data_i[0];
          RegXfMs:      xf_ms_q  <= cfg_data_i[15:0];
          RegHeight:    height_q <= cfg_data_i[15:0];
          RegCount: begin
            count_q <= cfg_data_i[2:0];
            cur_q <= '0; prev_q <= '0; prog_q <= FullFade;
          end
          RegThresh:    thr_q    <= cfg_data_i;
          default: ;
        endcase
      end else if (cmd_i.commit) begin
        cur_q <= cur_d; prev_q <= prev_d; timer_q <= timer_d; prog_q <= prog_d;
        active_level_o <= cur_d;
        fading_from_o  <= prev_d;
        fade_amount_o  <= prog_d;
        switched_o     <= (cur_d != cur_q);
      end
    end
  end
endmodule
